// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BRF_ASSERT_IMP(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (cons)) \
        else $error("brf: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define BRF_ASSERT_NXT(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (cons)) \
        else $error("brf: next-cycle check failed");

`endif

// ----- src/brf_pkg.sv -----
package brf_pkg;

    // Loop cap and tolerance reset
    localparam int unsigned MAX_HALVINGS = 40;
    localparam logic [20:0] TOL_RESET = 21'd1049;

    // Datapath widths that do not vary
    localparam int unsigned CORDIC_W = 34;
    localparam int unsigned SQ_W     = 36;

    // Angle and gain constants in Q.30
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

    // Square saturation bound, 2^35
    localparam logic signed [63:0] SQ_CLAMP = 64'sd34359738368;

    // Control between the sequencer and the function unit
    typedef struct packed {
        logic start;
        logic sel;
    } feval_req_t;

    typedef struct packed {
        logic done;
    } feval_rsp_t;

    // Arctangent table in Q.30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/brf_feval.sv -----
module brf_feval #(
    parameter int FRAC_BITS    = 20,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  brf_pkg::feval_req_t      req,
    input  logic signed [27:0]       x,
    output brf_pkg::feval_rsp_t      rsp,
    output logic signed [63:0]       fx
);

    localparam int SH  = 30 - FRAC_BITS;
    localparam int S   = (FRAC_BITS < 25) ? (25 - FRAC_BITS) : 0;
    localparam int RW  = 35 + S;
    localparam int KW  = $clog2(S + 2);
    localparam int SCW = $clog2(CORDIC_STEPS);
    localparam int CW  = brf_pkg::CORDIC_W;
    localparam logic signed [63:0] C04 =
        ((64'sd1 <<< (FRAC_BITS + 2)) + 64'sd5) / 64'sd10;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_RED, F_FOLD, F_CORD
    } fstate_t;

    fstate_t                 state_reg, state_next;
    logic                    sel_reg, sel_next;
    logic signed [27:0]      x_reg, x_next;
    logic [1:0]              ph_reg, ph_next;
    logic signed [63:0]      acc_reg, acc_next;
    logic [brf_pkg::SQ_W-1:0] sq_reg, sq_next;
    logic signed [63:0]      cube_reg, cube_next;
    logic signed [RW-1:0]    n_reg, n_next;
    logic signed [RW-1:0]    div_reg, div_next;
    logic [KW-1:0]           k_reg, k_next;
    logic signed [CW-1:0]    cx_reg, cx_next;
    logic signed [CW-1:0]    cy_reg, cy_next;
    logic signed [CW-1:0]    z_reg, z_next;
    logic [SCW-1:0]          step_reg, step_next;
    logic signed [63:0]      fx_reg, fx_next;
    logic                    done_reg, done_next;

    logic signed [18:0]      mul_b;
    logic signed [46:0]      prod;
    logic signed [63:0]      prod64;
    logic signed [63:0]      sum;
    logic signed [63:0]      sq_full;
    logic signed [RW-1:0]    n_sub;
    logic signed [RW-1:0]    r_red;
    logic signed [CW-1:0]    dx, dy, at;

    // Select the multiplier slice for the current phase
    always_comb begin
        case (ph_reg)
            2'd0:    mul_b = {1'b0, x_reg[17:0]};
            2'd1:    mul_b = {{9{x_reg[27]}}, x_reg[27:18]};
            2'd2:    mul_b = {1'b0, sq_reg[17:0]};
            default: mul_b = {1'b0, sq_reg[35:18]};
        endcase
    end

    assign prod    = x_reg * mul_b;
    assign prod64  = 64'(prod);
    assign sum     = acc_reg + (prod64 <<< 18);
    assign sq_full = sum >>> FRAC_BITS;
    assign n_sub   = (n_reg >= div_reg) ? (n_reg - div_reg) : n_reg;
    assign r_red   = n_reg - RW'(brf_pkg::PI_Q30);
    assign dx      = cy_reg >>> step_reg;
    assign dy      = cx_reg >>> step_reg;
    assign at      = CW'({1'b0, brf_pkg::atan_q30(5'(step_reg))});

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        x_next     = x_reg;
        ph_next    = ph_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        cube_next  = cube_reg;
        n_next     = n_reg;
        div_next   = div_reg;
        k_next     = k_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        z_next     = z_reg;
        step_next  = step_reg;
        fx_next    = fx_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            F_IDLE: begin
                // Latch operand and start the square
                if (req.start) begin
                    sel_next   = req.sel;
                    x_next     = x;
                    ph_next    = 2'd0;
                    state_next = F_MUL;
                end
            end
            F_MUL: begin
                // Two partial products per multiply
                ph_next = ph_reg + 2'd1;
                unique case (ph_reg)
                    2'd0, 2'd2: acc_next = prod64;
                    2'd1: begin
                        if (sq_full > brf_pkg::SQ_CLAMP) begin
                            sq_next = brf_pkg::SQ_CLAMP[brf_pkg::SQ_W-1:0];
                        end else begin
                            sq_next = sq_full[brf_pkg::SQ_W-1:0];
                        end
                    end
                    default: begin
                        cube_next = sq_full;
                        if (sel_reg) begin
                            fx_next    = sq_full + C04;
                            done_next  = 1'b1;
                            state_next = F_IDLE;
                        end else begin
                            n_next = (RW'(x_reg) <<< SH) + RW'(brf_pkg::PI_Q30)
                                   + (RW'(brf_pkg::TWO_PI_Q30) <<< S);
                            div_next   = RW'(brf_pkg::TWO_PI_Q30) <<< S;
                            k_next     = KW'(S);
                            state_next = F_RED;
                        end
                    end
                endcase
            end
            F_RED: begin
                // Restoring reduction by 2*pi, one multiple per cycle
                n_next   = n_sub;
                div_next = div_reg >>> 1;
                k_next   = k_reg - KW'(1);
                if (k_reg == '0) begin
                    state_next = F_FOLD;
                end
            end
            F_FOLD: begin
                // Fold into [-pi/2, pi/2] and seed the rotation
                if (r_red > RW'(brf_pkg::HALF_PI_Q30)) begin
                    z_next = CW'(RW'(brf_pkg::PI_Q30) - r_red);
                end else if (r_red < -RW'(brf_pkg::HALF_PI_Q30)) begin
                    z_next = CW'(-RW'(brf_pkg::PI_Q30) - r_red);
                end else begin
                    z_next = CW'(r_red);
                end
                cx_next    = CW'(brf_pkg::GAIN_Q30);
                cy_next    = '0;
                step_next  = '0;
                state_next = F_CORD;
            end
            F_CORD: begin
                // One rotation step per cycle
                if (z_reg >= 0) begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    z_next  = z_reg - at;
                end else begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    z_next  = z_reg + at;
                end
                step_next = step_reg + SCW'(1);
                if (step_reg == SCW'(CORDIC_STEPS - 1)) begin
                    fx_next    = cube_reg + 64'(cy_next >>> SH);
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        sel_reg  <= sel_next;
        x_reg    <= x_next;
        ph_reg   <= ph_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        cube_reg <= cube_next;
        n_reg    <= n_next;
        div_reg  <= div_next;
        k_reg    <= k_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        z_reg    <= z_next;
        step_reg <= step_next;
        fx_reg   <= fx_next;
    end

    assign rsp.done = done_reg;
    assign fx       = fx_reg;

endmodule

// ----- src/bisection_root_finder_top.sv -----
// Bisection root finder.
// Input beat (s_valid/s_ready): function select and two Q8.20 interval ends.
// Result beat (m_valid/m_ready): last midpoint, halving count, and a flag set
// when the interval was already within twice the tolerance.
// cfg_wr_en/cfg_wr_data write the tolerance (unsigned Q1.20); the user must
// write it only while the block is idle, which the block itself does not
// enforce. One item at a time: s_ready drops after a beat is taken until its
// result is loaded into the output register.
// An already narrow interval needs no function evaluation; otherwise one
// evaluation for the left end plus one per halving, up to 40 halvings, each
// paced by the shared multiplier for the 0.4 + x^3 form and also by the 2*pi
// reduction loop and the rotation loop for sin(x) + x^3.
// Reset returns the sequencer to idle, drops m_valid and loads the tolerance
// with 1049. A stalled receiver holds the result in the output register; a
// finished item waits there and the next beat may still be accepted.
`include "assert_macros.svh"

module bisection_root_finder_top #(
    parameter int FRAC_BITS    = 20,
    parameter int CORDIC_STEPS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [20:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic signed [27:0] s_left_end,
    input  logic signed [27:0] s_right_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [27:0] m_root,
    output logic [5:0]         m_halvings,
    output logic               m_already_narrow
);

    typedef enum logic [1:0] {
        T_IDLE, T_CHECK, T_EVA, T_EVM
    } tstate_t;

    tstate_t             state_reg, state_next;
    logic [20:0]         tol_reg, tol_next;
    logic                sel_reg, sel_next;
    logic signed [27:0]  a_reg, a_next;
    logic signed [27:0]  b_reg, b_next;
    logic signed [27:0]  mid_reg, mid_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic signed [63:0]  fa_reg, fa_next;
    logic                m_valid_reg, m_valid_next;
    logic signed [27:0]  m_root_reg, m_root_next;
    logic [5:0]          m_halvings_reg, m_halvings_next;
    logic                m_already_narrow_reg, m_already_narrow_next;

    brf_pkg::feval_req_t ev_req;
    brf_pkg::feval_rsp_t ev_rsp;
    logic signed [27:0]  ev_x;
    logic signed [63:0]  fx;

    logic signed [28:0]  ab_sum, in_sum, diff;
    logic [28:0]         abs_diff;
    logic signed [27:0]  mid_ab;
    logic                stop;
    logic                opposite;

    brf_feval #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_feval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ev_req),
        .x       (ev_x),
        .rsp     (ev_rsp),
        .fx      (fx)
    );

    // Interval arithmetic
    assign ab_sum   = 29'(a_reg) + 29'(b_reg);
    assign in_sum   = 29'(s_left_end) + 29'(s_right_end);
    assign mid_ab   = ab_sum[28:1];
    assign diff     = 29'(a_reg) - 29'(b_reg);
    assign abs_diff = diff[28] ? 29'(-diff) : 29'(diff);
    assign stop     = (abs_diff <= 29'({tol_reg, 1'b0}))
                   || (cnt_reg >= 6'(brf_pkg::MAX_HALVINGS));
    assign opposite = (fa_reg == '0) || (fx == '0) || (fa_reg[63] != fx[63]);

    assign s_ready = (state_reg == T_IDLE);
    assign ev_x    = (state_reg == T_CHECK && cnt_reg == '0) ? a_reg : mid_ab;

    always_comb begin
        state_next            = state_reg;
        tol_next              = tol_reg;
        sel_next              = sel_reg;
        a_next                = a_reg;
        b_next                = b_reg;
        mid_next              = mid_reg;
        cnt_next              = cnt_reg;
        fa_next               = fa_reg;
        m_valid_next          = m_valid_reg && !m_ready;
        m_root_next           = m_root_reg;
        m_halvings_next       = m_halvings_reg;
        m_already_narrow_next = m_already_narrow_reg;
        ev_req.start          = 1'b0;
        ev_req.sel            = sel_reg;

        // Tolerance write
        if (cfg_wr_en) begin
            tol_next = cfg_wr_data;
        end

        unique case (state_reg)
            T_IDLE: begin
                // Take a beat and seed the midpoint
                if (s_valid) begin
                    sel_next   = s_func;
                    a_next     = s_left_end;
                    b_next     = s_right_end;
                    mid_next   = in_sum[28:1];
                    cnt_next   = '0;
                    state_next = T_CHECK;
                end
            end
            T_CHECK: begin
                if (stop) begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_next          = 1'b1;
                        m_root_next           = mid_reg;
                        m_halvings_next       = cnt_reg;
                        m_already_narrow_next = (cnt_reg == '0);
                        state_next            = T_IDLE;
                    end
                end else if (cnt_reg == '0) begin
                    ev_req.start = 1'b1;
                    state_next   = T_EVA;
                end else begin
                    ev_req.start = 1'b1;
                    mid_next     = mid_ab;
                    state_next   = T_EVM;
                end
            end
            T_EVA: begin
                // Left end value ready: evaluate the midpoint next
                if (ev_rsp.done) begin
                    fa_next      = fx;
                    ev_req.start = 1'b1;
                    mid_next     = mid_ab;
                    state_next   = T_EVM;
                end
            end
            T_EVM: begin
                // Keep the half that brackets a sign change
                if (ev_rsp.done) begin
                    if (opposite) begin
                        b_next = mid_reg;
                    end else begin
                        a_next  = mid_reg;
                        fa_next = fx;
                    end
                    cnt_next   = cnt_reg + 6'd1;
                    state_next = T_CHECK;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            tol_reg     <= brf_pkg::TOL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tol_reg     <= tol_next;
            m_valid_reg <= m_valid_next;
        end
        sel_reg              <= sel_next;
        a_reg                <= a_next;
        b_reg                <= b_next;
        mid_reg              <= mid_next;
        cnt_reg              <= cnt_next;
        fa_reg               <= fa_next;
        m_root_reg           <= m_root_next;
        m_halvings_reg       <= m_halvings_next;
        m_already_narrow_reg <= m_already_narrow_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_root           = m_root_reg;
    assign m_halvings       = m_halvings_reg;
    assign m_already_narrow = m_already_narrow_reg;

    // Result fields stay consistent with the loop cap and with each other
    `BRF_ASSERT_IMP(a_cnt_cap, aclk, aresetn, m_valid_reg, m_halvings_reg <= 6'(brf_pkg::MAX_HALVINGS))
    `BRF_ASSERT_IMP(a_narrow_flag, aclk, aresetn, m_valid_reg, m_already_narrow_reg == (m_halvings_reg == 6'd0))
    // No second beat while an item is in flight
    `BRF_ASSERT_NXT(a_busy_after_beat, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule
